// ----- hw/rtl/vcfb_pkg.sv -----
// ----------------------------------------------------------------------------
// vcfb_pkg
// Shared types and codes of the virtual channel flit buffer: word layouts,
// status and priority mode codes, register indexes and the back-end states.
// ----------------------------------------------------------------------------
package vcfb_pkg;

  // Default number of flit slots
  localparam int DEFAULT_BUFFER_DEPTH = 16;

  // Configuration port layout
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PRIORITY_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_DONATION      = 1'b1;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_FULL     = 2'd3;

  // Priority modes; codes above MODE_CARRIED act as carried priority
  localparam logic [2:0] MODE_NONE    = 3'd0;
  localparam logic [2:0] MODE_AGE     = 3'd1;
  localparam logic [2:0] MODE_QLEN    = 3'd2;
  localparam logic [2:0] MODE_HOPS    = 3'd3;
  localparam logic [2:0] MODE_CARRIED = 3'd4;

  localparam logic [30:0] PRIO_MAX = 31'h7FFF_FFFF;

  // Live configuration
  typedef struct packed {
    logic [2:0] mode;
    logic       donate;
  } cfg_t;

  // Classified input word handed from front to back
  typedef struct packed {
    logic        op;
    logic [31:0] flit_id;
    logic [31:0] packet_id;
    logic        tail;
    logic [7:0]  hops;
    logic [30:0] prio;
  } item_t;

  // One buffered flit
  typedef struct packed {
    logic [31:0] flit_id;
    logic [31:0] packet_id;
    logic        tail;
    logic [7:0]  hops;
    logic [30:0] prio;
  } slot_t;

  // One result word
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flit_id;
    logic [31:0] packet_id;
    logic        tail;
    logic [7:0]  hops;
    logic [30:0] prio;
    logic [30:0] channel_prio;
    logic [4:0]  fill;
  } result_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_DATA,
    ST_SCAN,
    ST_FINISH
  } back_state_t;

endpackage

// ----- hw/rtl/vcfb_front.sv -----
// ----------------------------------------------------------------------------
// vcfb_front
// Input side: takes words from the push port, assigns the flit priority
// from the active mode and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module vcfb_front (
  input  logic            clk,
  input  logic            rst,
  input  vcfb_pkg::cfg_t  cfg,
  input  logic            push,
  output logic            full,
  input  logic            op,
  input  logic [31:0]     flit_id,
  input  logic [31:0]     packet_id,
  input  logic            is_tail,
  input  logic [7:0]      hops,
  input  logic [30:0]     carried_priority,
  input  logic [30:0]     current_time,
  output logic            item_valid,
  output vcfb_pkg::item_t item,
  input  logic            take
);

  vcfb_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            accept;
  vcfb_pkg::item_t classified;
  logic [30:0]     prio;

  // Flit priority by mode
  always_comb begin
    unique case (cfg.mode)
      vcfb_pkg::MODE_AGE:  prio = vcfb_pkg::PRIO_MAX - current_time;
      vcfb_pkg::MODE_HOPS: prio = 31'(hops);
      default:             prio = carried_priority;
    endcase
  end

  always_comb begin
    classified.op        = op;
    classified.flit_id   = flit_id;
    classified.packet_id = packet_id;
    classified.tail      = is_tail;
    classified.hops      = hops;
    classified.prio      = prio;
  end

  assign full       = (count == 2'd2);
  assign accept     = push && !full;
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= classified;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({accept, take})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/vcfb_back.sv -----
// ----------------------------------------------------------------------------
// vcfb_back
// Execution side: flit memory, packet continuity check, pointers, channel
// priority recompute (a scan over the memory's read port) and result register.
// ----------------------------------------------------------------------------
module vcfb_back #(
  parameter int BUFFER_DEPTH = vcfb_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  vcfb_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  vcfb_pkg::item_t   item,
  output logic              take,
  output logic              res_valid,
  output vcfb_pkg::result_t res,
  input  logic              pop
);

  localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int OCC_W = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W = $clog2(2 * BUFFER_DEPTH);

  // Ring slot at a distance from a base pointer
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [OCC_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(BUFFER_DEPTH)) begin
      sum = sum - SUM_W'(BUFFER_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  vcfb_pkg::back_state_t state, state_next;

  vcfb_pkg::slot_t mem [BUFFER_DEPTH];
  vcfb_pkg::slot_t rd_data;
  vcfb_pkg::slot_t wr_data;
  logic            mem_we;
  logic [PTR_W-1:0] waddr;
  logic [PTR_W-1:0] raddr;

  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] head_inc;
  logic [OCC_W-1:0] occ;
  logic             expecting;
  logic [31:0]      expected;
  logic [30:0]      vc_prio;

  logic [1:0]       cur_status;
  logic [31:0]      cur_fid;
  logic [31:0]      cur_pid;
  logic             cur_tail;
  logic [7:0]       cur_hops;
  logic [30:0]      cur_prio;

  logic [OCC_W-1:0] scan_len;
  logic [OCC_W-1:0] issued;
  logic             rd_pend;
  logic             rd_issue;
  logic [30:0]      best;
  logic             best_vld;
  logic [30:0]      best_next;

  logic             mismatch;
  logic             is_full;
  logic             push_ok;
  logic             pop_ok;
  logic [1:0]       take_status;
  logic [OCC_W-1:0] rc_occ;
  logic             rc_qlen;
  logic             rc_scan;
  logic             donate_scan;
  logic [OCC_W-1:0] rc_len;
  logic             out_free;

  // Checks on the word at the front of the queue
  assign mismatch = expecting && (item.packet_id != expected);
  assign is_full  = (occ == OCC_W'(BUFFER_DEPTH));
  assign push_ok  = (item.op == vcfb_pkg::OP_PUSH) && !mismatch && !is_full;
  assign pop_ok   = (item.op == vcfb_pkg::OP_POP) && (occ != '0);
  assign head_inc = slot_of(head, OCC_W'(1));
  assign out_free = !res_valid || pop;

  always_comb begin
    if (item.op == vcfb_pkg::OP_POP) begin
      take_status = (occ == '0) ? vcfb_pkg::STATUS_EMPTY : vcfb_pkg::STATUS_OK;
    end else if (mismatch) begin
      take_status = vcfb_pkg::STATUS_MISMATCH;
    end else if (is_full) begin
      take_status = vcfb_pkg::STATUS_FULL;
    end else begin
      take_status = vcfb_pkg::STATUS_OK;
    end
  end

  // Recompute setup: occupancy after the push or pop under way
  assign rc_occ      = (state == vcfb_pkg::ST_POP_DATA) ? occ - OCC_W'(1) : occ + OCC_W'(1);
  assign rc_qlen     = (rc_occ != '0) && (cfg.mode == vcfb_pkg::MODE_QLEN);
  assign rc_scan     = (rc_occ != '0) && (cfg.mode != vcfb_pkg::MODE_NONE)
                       && (cfg.mode != vcfb_pkg::MODE_QLEN);
  assign donate_scan = cfg.donate && (cfg.mode != vcfb_pkg::MODE_AGE);
  assign rc_len      = donate_scan ? rc_occ : OCC_W'(1);

  assign best_next = (!best_vld || (rd_data.prio > best)) ? rd_data.prio : best;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      vcfb_pkg::ST_IDLE: begin
        if (item_valid) begin
          if (item.op == vcfb_pkg::OP_POP) begin
            state_next = pop_ok ? vcfb_pkg::ST_POP_DATA : vcfb_pkg::ST_FINISH;
          end else begin
            state_next = (push_ok && rc_scan) ? vcfb_pkg::ST_SCAN : vcfb_pkg::ST_FINISH;
          end
        end
      end
      vcfb_pkg::ST_POP_DATA: begin
        state_next = rc_scan ? vcfb_pkg::ST_SCAN : vcfb_pkg::ST_FINISH;
      end
      vcfb_pkg::ST_SCAN: begin
        if (rd_pend && (issued == scan_len)) begin
          state_next = vcfb_pkg::ST_FINISH;
        end
      end
      vcfb_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = vcfb_pkg::ST_IDLE;
        end
      end
      default: state_next = vcfb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and memory port control
  always_comb begin
    take     = 1'b0;
    mem_we   = 1'b0;
    rd_issue = 1'b0;
    raddr    = head;
    waddr    = slot_of(head, occ);
    unique case (state)
      vcfb_pkg::ST_IDLE: begin
        take   = item_valid;
        mem_we = item_valid && push_ok;
      end
      vcfb_pkg::ST_SCAN: begin
        rd_issue = (issued != scan_len);
        raddr    = slot_of(head, issued);
      end
      default: begin
        take = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_data.flit_id   = item.flit_id;
    wr_data.packet_id = item.packet_id;
    wr_data.tail      = item.tail;
    wr_data.hops      = item.hops;
    wr_data.prio      = item.prio;
  end

  // Flit memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wr_data;
    end
    rd_data <= mem[raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= vcfb_pkg::ST_IDLE;
      head      <= '0;
      occ       <= '0;
      expecting <= 1'b0;
      expected  <= '0;
      vc_prio   <= '0;
      res_valid <= 1'b0;
      rd_pend   <= 1'b0;
      issued    <= '0;
      scan_len  <= '0;
      best_vld  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_issue;
      // Result register: loaded on finish, cleared once taken
      if (state == vcfb_pkg::ST_FINISH && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        vcfb_pkg::ST_IDLE: begin
          if (item_valid && push_ok) begin
            occ <= rc_occ;
            if (expecting) begin
              if (item.tail) begin
                expecting <= 1'b0;
              end
            end else if (!item.tail) begin
              expecting <= 1'b1;
              expected  <= item.packet_id;
            end
            if (rc_qlen) begin
              vc_prio <= 31'(rc_occ);
            end
            scan_len <= rc_len;
            issued   <= '0;
            best_vld <= 1'b0;
          end
        end
        vcfb_pkg::ST_POP_DATA: begin
          head <= head_inc;
          occ  <= rc_occ;
          if (rc_qlen) begin
            vc_prio <= 31'(rc_occ);
          end
          scan_len <= rc_len;
          issued   <= '0;
          best_vld <= 1'b0;
        end
        vcfb_pkg::ST_SCAN: begin
          if (rd_issue) begin
            issued <= issued + OCC_W'(1);
          end
          if (rd_pend) begin
            best_vld <= 1'b1;
            if (issued == scan_len) begin
              vc_prio <= best_next;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Word under way and result payload
  always_ff @(posedge clk) begin
    if (state == vcfb_pkg::ST_IDLE && item_valid) begin
      cur_status <= take_status;
      cur_fid    <= '0;
      cur_pid    <= '0;
      cur_tail   <= 1'b0;
      cur_hops   <= '0;
      cur_prio   <= '0;
    end
    if (state == vcfb_pkg::ST_POP_DATA) begin
      cur_fid  <= rd_data.flit_id;
      cur_pid  <= rd_data.packet_id;
      cur_tail <= rd_data.tail;
      cur_hops <= rd_data.hops;
      cur_prio <= rd_data.prio;
    end
    if (state == vcfb_pkg::ST_SCAN && rd_pend) begin
      best <= best_next;
    end
    if (state == vcfb_pkg::ST_FINISH && out_free) begin
      res.status       <= cur_status;
      res.flit_id      <= cur_fid;
      res.packet_id    <= cur_pid;
      res.tail         <= cur_tail;
      res.hops         <= cur_hops;
      res.prio         <= cur_prio;
      res.channel_prio <= vc_prio;
      res.fill         <= 5'(occ);
    end
  end

endmodule

// ----- hw/rtl/virtual_channel_flit_buffer_core.sv -----
// ----------------------------------------------------------------------------
// virtual_channel_flit_buffer_core
// Input virtual channel flit buffer of a network-on-chip router.
// ----------------------------------------------------------------------------
// Words are pushed (a flit push or a pop request) and one result word per
// input word comes out in order on the result side. A front end classifies
// each word and holds up to two in a queue; the back end runs them one at a
// time against a single-port-read flit memory of BUFFER_DEPTH slots. A push
// is written as it is taken and a pop reads the head slot first; both are
// followed by a channel priority recompute when the mode uses flit
// priorities and the buffer is not left empty. The recompute scans the head
// flit only without donation or in age mode, and every buffered flit with
// donation, since each priority is read through the memory's one read port.
// A failed word and modes none and queue length take no recompute. The back
// end also waits while the previous result word has not been popped.
// ----------------------------------------------------------------------------
module virtual_channel_flit_buffer_core #(
  parameter int BUFFER_DEPTH = vcfb_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // push side
  input  logic                            push,
  output logic                            full,
  input  logic                            op,
  input  logic [31:0]                     flit_id,
  input  logic [31:0]                     packet_id,
  input  logic                            is_tail,
  input  logic [7:0]                      hops,
  input  logic [30:0]                     carried_priority,
  input  logic [30:0]                     current_time,
  // result side
  output logic                            empty,
  input  logic                            pop,
  output logic [1:0]                      status,
  output logic [31:0]                     popped_flit_id,
  output logic [31:0]                     popped_packet_id,
  output logic                            popped_tail,
  output logic [7:0]                      popped_hops,
  output logic [30:0]                     popped_priority,
  output logic [30:0]                     channel_priority,
  output logic [4:0]                      fill_level,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [vcfb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vcfb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  vcfb_pkg::cfg_t    cfg;
  vcfb_pkg::item_t   item;
  vcfb_pkg::result_t res;
  logic              item_valid;
  logic              take;
  logic              res_valid;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= vcfb_pkg::MODE_NONE;
      cfg.donate <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vcfb_pkg::REG_PRIORITY_MODE: cfg.mode   <= cfg_data[2:0];
        vcfb_pkg::REG_DONATION:      cfg.donate <= cfg_data[0];
        default:                     cfg.donate <= cfg.donate;
      endcase
    end
  end

  vcfb_front u_front (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .push             (push),
    .full             (full),
    .op               (op),
    .flit_id          (flit_id),
    .packet_id        (packet_id),
    .is_tail          (is_tail),
    .hops             (hops),
    .carried_priority (carried_priority),
    .current_time     (current_time),
    .item_valid       (item_valid),
    .item             (item),
    .take             (take)
  );

  vcfb_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .pop        (pop)
  );

  // Result ports
  assign empty            = !res_valid;
  assign status           = res.status;
  assign popped_flit_id   = res.flit_id;
  assign popped_packet_id = res.packet_id;
  assign popped_tail      = res.tail;
  assign popped_hops      = res.hops;
  assign popped_priority  = res.prio;
  assign channel_priority = res.channel_prio;
  assign fill_level       = res.fill;

endmodule

// ----- hw/rtl/vcfb_checker.sv -----
// ----------------------------------------------------------------------------
// vcfb_checker
// Port-level checks of the flit buffer: reset state, result hold, and
// consistency between status, popped fields and fill level.
// ----------------------------------------------------------------------------
module vcfb_checker #(
  parameter int BUFFER_DEPTH = vcfb_pkg::DEFAULT_BUFFER_DEPTH
) (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  status,
  input logic [31:0] popped_flit_id,
  input logic [30:0] popped_priority,
  input logic [4:0]  fill_level
);

  // Reset leaves both sides empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("buffer not empty after reset");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(fill_level))
    else $error("result changed before pop");

  // Failed words report no popped flit
  a_fail_no_flit: assert property (@(posedge clk) disable iff (rst)
    !empty && status != vcfb_pkg::STATUS_OK |-> popped_flit_id == 32'd0
      && popped_priority == 31'd0)
    else $error("failed word carries popped flit data");

  // Empty pop and full push agree with the fill level
  a_fill_status: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status != vcfb_pkg::STATUS_EMPTY || fill_level == 5'd0)
      && (status != vcfb_pkg::STATUS_FULL || fill_level == 5'(BUFFER_DEPTH)))
    else $error("status disagrees with fill level");

  // Fill level within the buffer size
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (BUFFER_DEPTH > 31) || (32'(fill_level) <= 32'(BUFFER_DEPTH)))
    else $error("fill level above buffer depth");

endmodule

bind virtual_channel_flit_buffer_core vcfb_checker #(
  .BUFFER_DEPTH (BUFFER_DEPTH)
) u_vcfb_checker (
  .clk             (clk),
  .rst             (rst),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .status          (status),
  .popped_flit_id  (popped_flit_id),
  .popped_priority (popped_priority),
  .fill_level      (fill_level)
);
